/* hw/rtl/hti_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Hash table insert engine package
// Shared sizes, codes, sequencer states and the prime lookup.
// ----------------------------------------------------------------------------
package hti_pkg;

  localparam int MAX_SLOTS   = 1024;
  localparam int SLOT_LOG    = 10;
  localparam int CHAIN_DEPTH = 8;
  localparam int CHAIN_LOG   = 3;
  localparam int STORE_DEPTH = MAX_SLOTS * CHAIN_DEPTH;
  localparam int STORE_AW    = SLOT_LOG + CHAIN_LOG;
  localparam int KEY_W       = 16;
  localparam int BKT_W       = SLOT_LOG;
  localparam int SLOTS_W     = SLOT_LOG + 1;
  localparam int HELD_W      = 14;
  localparam int FILL_W      = 4;
  localparam int COLL_W      = 32;
  localparam int SIZE_W      = 4;

  typedef enum logic [1:0] {
    MODE_LINEAR,
    MODE_DOUBLE,
    MODE_CHAIN,
    MODE_RSVD
  } mode_t;

  typedef enum logic [1:0] {
    ST_STORED,
    ST_GROWN,
    ST_TABLE_FULL,
    ST_CHAIN_FULL
  } status_t;

  typedef enum logic [3:0] {
    S_CLR,
    S_IDLE,
    S_PL,
    S_H2,
    S_P_RD,
    S_P_CHK,
    S_C_CHK,
    S_NEXT,
    S_R_RD,
    S_R_LD,
    S_G_FILL,
    S_G_FW,
    S_G_SR,
    S_G_SW,
    S_DONE
  } state_t;

  // Largest value below the slot count with no divisor between 2 and itself.
  function automatic logic [BKT_W-1:0] prime_below(input logic [SIZE_W-1:0] lg);
    logic [BKT_W-1:0] p;
    case (lg)
      4'd1:    p = 10'd1;
      4'd2:    p = 10'd3;
      4'd3:    p = 10'd7;
      4'd4:    p = 10'd13;
      4'd5:    p = 10'd31;
      4'd6:    p = 10'd61;
      4'd7:    p = 10'd127;
      4'd8:    p = 10'd251;
      4'd9:    p = 10'd509;
      4'd10:   p = 10'd1021;
      default: p = 10'd0;
    endcase
    return p;
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/hti_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module hti_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* hw/rtl/hti_h2_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Secondary hash unit
// Squares the key, then takes the remainder by the prime one bit a cycle.
// ----------------------------------------------------------------------------
module hti_h2_unit (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  input  wire logic [hti_pkg::KEY_W-1:0] key,
  input  wire logic [hti_pkg::BKT_W-1:0] divisor,
  output logic                           done,
  output logic      [hti_pkg::BKT_W-1:0] rem
);
  import hti_pkg::*;

  logic [31:0]      sq_r;
  logic [BKT_W-1:0] rem_r;
  logic [BKT_W-1:0] div_r;
  logic [5:0]       cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [BKT_W:0]   shifted;
  logic [BKT_W:0]   diff;
  logic [BKT_W-1:0] rem_step;

  // One restoring remainder step.
  always_comb begin
    shifted  = {rem_r, sq_r[31]};
    diff     = shifted - {1'b0, div_r};
    rem_step = (shifted >= {1'b0, div_r}) ? diff[BKT_W-1:0] : shifted[BKT_W-1:0];
  end

  // Control of the iteration.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 6'd0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 6'd32;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Square and remainder datapath.
  always_ff @(posedge clk) begin
    if (start) begin
      sq_r  <= {16'd0, key} * {16'd0, key};
      rem_r <= '0;
      div_r <= divisor;
    end else if (busy_r) begin
      sq_r  <= {sq_r[30:0], 1'b0};
      rem_r <= rem_step;
    end
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule
`default_nettype wire

/* hw/rtl/hash_table_insert_engine.sv */
`default_nettype none
// A zero key goes straight to the result as table full. Probed inserts read the fill
// memory once per probe, after the square-remainder unit in double hashing mode.
// Growth reads every bucket's fill and each held key, then re-places every key.
// One word is processed at a time; a new key is taken only once the last result is handed on.
// After reset the fill memory is swept while in_ready stays low.
// ----------------------------------------------------------------------------
// Hash table insert engine
// Inserts keys by linear probing, offset double hashing or chaining, with
// table growth and rehash through a scratch memory.
// ----------------------------------------------------------------------------
module hash_table_insert_engine (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [hti_pkg::KEY_W-1:0]   in_key,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic      [hti_pkg::BKT_W-1:0]   out_bucket_index,
  output logic      [1:0]                  out_status,
  output logic      [hti_pkg::COLL_W-1:0]  out_collision_total,
  output logic      [hti_pkg::SLOTS_W-1:0] out_slot_count,
  output logic      [hti_pkg::HELD_W-1:0]  out_entries_held,
  input  wire logic                        cfg_we,
  input  wire logic [1:0]                  cfg_wdata
);
  import hti_pkg::*;

  // Registers.
  state_t               state_r, state_nxt;
  mode_t                mode_r;
  logic [BKT_W-1:0]     clr_r, clr_nxt;
  logic [KEY_W-1:0]     key_r, key_nxt;
  logic [KEY_W-1:0]     cur_key_r, cur_key_nxt;
  logic                 grown_r, grown_nxt;
  logic                 rehash_r, rehash_nxt;
  logic [SIZE_W-1:0]    size_log_r, size_log_nxt;
  logic [HELD_W-1:0]    held_r, held_nxt;
  logic [COLL_W-1:0]    coll_r, coll_nxt;
  logic [BKT_W-1:0]     i_r, i_nxt;
  logic [BKT_W-1:0]     h2_r, h2_nxt;
  logic [BKT_W-1:0]     b_r, b_nxt;
  logic [FILL_W-1:0]    f_r, f_nxt;
  logic [FILL_W-1:0]    j_r, j_nxt;
  logic [HELD_W-1:0]    cnt_r, cnt_nxt;
  logic [HELD_W-1:0]    rj_r, rj_nxt;
  logic [BKT_W-1:0]     where_r, where_nxt;
  status_t              stat_r, stat_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [BKT_W-1:0]     o_bkt_r, o_bkt_nxt;
  status_t              o_stat_r, o_stat_nxt;
  logic [COLL_W-1:0]    o_coll_r, o_coll_nxt;
  logic [SLOTS_W-1:0]   o_slots_r, o_slots_nxt;
  logic [HELD_W-1:0]    o_held_r, o_held_nxt;

  // Memory ports.
  logic                 fill_we;
  logic [BKT_W-1:0]     fill_waddr, fill_raddr;
  logic [FILL_W-1:0]    fill_wdata, fill_rdata;
  logic                 store_we;
  logic [STORE_AW-1:0]  store_waddr, store_raddr;
  logic [KEY_W-1:0]     store_wdata, store_rdata;
  logic                 scr_we;
  logic [STORE_AW-1:0]  scr_waddr, scr_raddr;
  logic [KEY_W-1:0]     scr_wdata, scr_rdata;

  // Secondary hash unit.
  logic                 h2_start, h2_done;
  logic [BKT_W-1:0]     h2_rem;

  // Derived values.
  logic [SLOTS_W-1:0]   slot_count;
  logic [BKT_W-1:0]     slot_mask;
  logic [BKT_W-1:0]     home;
  logic [BKT_W+1:0]     probe_sum;
  logic [BKT_W-1:0]     probe_idx;
  mode_t                mode_eff;
  logic [BKT_W-1:0]     prime;
  logic                 need_h2;
  logic                 load_hit;
  logic                 in_acc;
  logic                 p_free, p_last, b_last, c_full, g_jlast, r_last, out_free;
  logic [2:0]           g_slot;
  logic [BKT_W-1:0]     coll_add;
  logic [COLL_W:0]      coll_sum;
  logic [COLL_W-1:0]    coll_sat;

  always_comb begin
    slot_count = SLOTS_W'(1) << size_log_r;
    slot_mask  = BKT_W'(slot_count - SLOTS_W'(1));
    home       = cur_key_r[BKT_W-1:0] & slot_mask;
    probe_sum  = (BKT_W+2)'(home) + (BKT_W+2)'(i_r) + (BKT_W+2)'(h2_r);
    probe_idx  = probe_sum[BKT_W-1:0] & slot_mask;
    mode_eff   = (mode_r == MODE_RSVD) ? MODE_LINEAR : mode_r;
    prime      = prime_below(size_log_r);
    need_h2    = (mode_eff == MODE_DOUBLE) && (prime != '0);
    load_hit   = (size_log_r < SIZE_W'(SLOT_LOG)) &&
                 ((18'(held_r) * 18'd10) >= (18'(slot_count) * 18'd7));
    in_acc     = in_valid && in_ready;
    p_free     = (fill_rdata == '0);
    p_last     = (i_r == slot_mask);
    b_last     = (b_r == slot_mask);
    c_full     = (fill_rdata >= FILL_W'(CHAIN_DEPTH));
    g_jlast    = ((j_r + FILL_W'(1)) == f_r);
    r_last     = ((rj_r + HELD_W'(1)) == cnt_r);
    out_free   = !out_valid_r || out_ready;
    g_slot     = 3'(f_r - FILL_W'(1) - j_r);
  end

  // Saturating collision add.
  always_comb begin
    coll_add = '0;
    if (state_r == S_P_CHK && p_free) begin
      coll_add = i_r;
    end else if (state_r == S_C_CHK && !c_full && !p_free) begin
      coll_add = BKT_W'(1);
    end
    coll_sum = {1'b0, coll_r} + (COLL_W+1)'(coll_add);
    coll_sat = coll_sum[COLL_W] ? '1 : coll_sum[COLL_W-1:0];
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLR: begin
        if (clr_r == '1) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_acc) begin
          if (in_key == '0)  state_nxt = S_DONE;
          else if (load_hit) state_nxt = S_G_FILL;
          else               state_nxt = S_PL;
        end
      end
      S_PL: begin
        if (mode_eff == MODE_CHAIN) state_nxt = S_C_CHK;
        else if (need_h2)           state_nxt = S_H2;
        else                        state_nxt = S_P_RD;
      end
      S_H2: begin
        if (h2_done) state_nxt = S_P_RD;
      end
      S_P_RD:  state_nxt = S_P_CHK;
      S_P_CHK: state_nxt = (p_free || p_last) ? S_NEXT : S_P_RD;
      S_C_CHK: state_nxt = S_NEXT;
      S_NEXT: begin
        if (rehash_r) state_nxt = r_last ? S_PL : S_R_RD;
        else          state_nxt = S_DONE;
      end
      S_R_RD:   state_nxt = S_R_LD;
      S_R_LD:   state_nxt = S_PL;
      S_G_FILL: state_nxt = S_G_FW;
      S_G_FW: begin
        if (!p_free)     state_nxt = S_G_SR;
        else if (!b_last) state_nxt = S_G_FILL;
        else             state_nxt = (cnt_r == '0) ? S_PL : S_R_RD;
      end
      S_G_SR: state_nxt = S_G_SW;
      S_G_SW: begin
        if (!g_jlast)    state_nxt = S_G_SR;
        else if (b_last) state_nxt = S_R_RD;
        else             state_nxt = S_G_FILL;
      end
      S_DONE: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_CLR;
    endcase
  end

  // Datapath, memory controls and handshake outputs.
  always_comb begin
    in_ready      = (state_r == S_IDLE);
    clr_nxt       = clr_r;
    key_nxt       = key_r;
    cur_key_nxt   = cur_key_r;
    grown_nxt     = grown_r;
    rehash_nxt    = rehash_r;
    size_log_nxt  = size_log_r;
    held_nxt      = held_r;
    coll_nxt      = coll_r;
    i_nxt         = i_r;
    h2_nxt        = h2_r;
    b_nxt         = b_r;
    f_nxt         = f_r;
    j_nxt         = j_r;
    cnt_nxt       = cnt_r;
    rj_nxt        = rj_r;
    where_nxt     = where_r;
    stat_nxt      = stat_r;
    o_bkt_nxt     = o_bkt_r;
    o_stat_nxt    = o_stat_r;
    o_coll_nxt    = o_coll_r;
    o_slots_nxt   = o_slots_r;
    o_held_nxt    = o_held_r;
    out_valid_nxt = out_valid_r && !out_ready;
    fill_we       = 1'b0;
    fill_waddr    = '0;
    fill_wdata    = '0;
    fill_raddr    = '0;
    store_we      = 1'b0;
    store_waddr   = '0;
    store_wdata   = cur_key_r;
    store_raddr   = '0;
    scr_we        = 1'b0;
    scr_waddr     = cnt_r[STORE_AW-1:0];
    scr_wdata     = store_rdata;
    scr_raddr     = rj_r[STORE_AW-1:0];
    h2_start      = 1'b0;

    case (state_r)
      // Sweep the fill memory after reset.
      S_CLR: begin
        fill_we    = 1'b1;
        fill_waddr = clr_r;
        clr_nxt    = clr_r + BKT_W'(1);
      end
      S_IDLE: begin
        if (in_acc) begin
          key_nxt     = in_key;
          cur_key_nxt = in_key;
          rehash_nxt  = 1'b0;
          if (in_key == '0) begin
            where_nxt = '0;
            stat_nxt  = ST_TABLE_FULL;
          end else begin
            grown_nxt = load_hit;
            b_nxt     = '0;
            cnt_nxt   = '0;
          end
        end
      end
      // Start one placement.
      S_PL: begin
        fill_raddr = home;
        i_nxt      = '0;
        h2_nxt     = '0;
        h2_start   = (mode_eff != MODE_CHAIN) && need_h2;
      end
      S_H2: begin
        h2_nxt = h2_rem;
      end
      S_P_RD: begin
        fill_raddr = probe_idx;
      end
      // Probe check: claim a free slot, report a full table, or move on.
      S_P_CHK: begin
        if (p_free) begin
          store_we    = 1'b1;
          store_waddr = {probe_idx, 3'd0};
          fill_we     = 1'b1;
          fill_waddr  = probe_idx;
          fill_wdata  = FILL_W'(1);
          coll_nxt    = coll_sat;
          held_nxt    = held_r + HELD_W'(1);
          where_nxt   = probe_idx;
          stat_nxt    = grown_r ? ST_GROWN : ST_STORED;
        end else if (p_last) begin
          where_nxt = home;
          stat_nxt  = ST_TABLE_FULL;
        end else begin
          i_nxt = i_r + BKT_W'(1);
        end
      end
      // Chain check: entries are kept oldest first, so a push appends.
      S_C_CHK: begin
        where_nxt = home;
        if (c_full) begin
          stat_nxt = ST_CHAIN_FULL;
        end else begin
          store_we    = 1'b1;
          store_waddr = {home, fill_rdata[2:0]};
          fill_we     = 1'b1;
          fill_waddr  = home;
          fill_wdata  = fill_rdata + FILL_W'(1);
          coll_nxt    = coll_sat;
          held_nxt    = held_r + HELD_W'(1);
          stat_nxt    = grown_r ? ST_GROWN : ST_STORED;
        end
      end
      // After a placement: next rehashed key, the new key itself, or the result.
      S_NEXT: begin
        if (rehash_r) begin
          if (r_last) begin
            rehash_nxt  = 1'b0;
            cur_key_nxt = key_r;
          end else begin
            rj_nxt = rj_r + HELD_W'(1);
          end
        end
      end
      S_R_LD: begin
        cur_key_nxt = scr_rdata;
      end
      // Gather pass: read each bucket's fill.
      S_G_FILL: begin
        fill_raddr = b_r;
      end
      S_G_FW: begin
        f_nxt = fill_rdata;
        j_nxt = '0;
        if (p_free) begin
          b_nxt = b_r + BKT_W'(1);
          if (b_last) begin
            size_log_nxt = size_log_r + SIZE_W'(1);
            held_nxt     = '0;
            rj_nxt       = '0;
            rehash_nxt   = (cnt_r != '0);
            cur_key_nxt  = key_r;
          end
        end
      end
      // Each chain is gathered newest entry first.
      S_G_SR: begin
        store_raddr = {b_r, g_slot};
      end
      S_G_SW: begin
        scr_we  = 1'b1;
        cnt_nxt = cnt_r + HELD_W'(1);
        j_nxt   = j_r + FILL_W'(1);
        if (g_jlast) begin
          fill_we    = 1'b1;
          fill_waddr = b_r;
          b_nxt      = b_r + BKT_W'(1);
          if (b_last) begin
            size_log_nxt = size_log_r + SIZE_W'(1);
            held_nxt     = '0;
            rj_nxt       = '0;
            rehash_nxt   = 1'b1;
          end
        end
      end
      // Hand the result word to the output register.
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          o_bkt_nxt     = where_r;
          o_stat_nxt    = stat_r;
          o_coll_nxt    = coll_r;
          o_slots_nxt   = slot_count;
          o_held_nxt    = held_r;
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      mode_r      <= MODE_LINEAR;
      size_log_r  <= '0;
      held_r      <= '0;
      coll_r      <= '0;
      rehash_r    <= 1'b0;
      grown_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      if (cfg_we) begin
        mode_r <= mode_t'(cfg_wdata);
      end
      size_log_r  <= size_log_nxt;
      held_r      <= held_nxt;
      coll_r      <= coll_nxt;
      rehash_r    <= rehash_nxt;
      grown_r     <= grown_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    key_r     <= key_nxt;
    cur_key_r <= cur_key_nxt;
    i_r       <= i_nxt;
    h2_r      <= h2_nxt;
    b_r       <= b_nxt;
    f_r       <= f_nxt;
    j_r       <= j_nxt;
    cnt_r     <= cnt_nxt;
    rj_r      <= rj_nxt;
    where_r   <= where_nxt;
    stat_r    <= stat_nxt;
    o_bkt_r   <= o_bkt_nxt;
    o_stat_r  <= o_stat_nxt;
    o_coll_r  <= o_coll_nxt;
    o_slots_r <= o_slots_nxt;
    o_held_r  <= o_held_nxt;
  end

  // Memories: chain fill per bucket, key store, rehash scratch.
  hti_ram #(.DEPTH(MAX_SLOTS), .WIDTH(FILL_W)) u_fill (
    .clk   (clk),
    .we    (fill_we),
    .waddr (fill_waddr),
    .wdata (fill_wdata),
    .raddr (fill_raddr),
    .rdata (fill_rdata)
  );

  hti_ram #(.DEPTH(STORE_DEPTH), .WIDTH(KEY_W)) u_store (
    .clk   (clk),
    .we    (store_we),
    .waddr (store_waddr),
    .wdata (store_wdata),
    .raddr (store_raddr),
    .rdata (store_rdata)
  );

  hti_ram #(.DEPTH(STORE_DEPTH), .WIDTH(KEY_W)) u_scratch (
    .clk   (clk),
    .we    (scr_we),
    .waddr (scr_waddr),
    .wdata (scr_wdata),
    .raddr (scr_raddr),
    .rdata (scr_rdata)
  );

  hti_h2_unit u_h2 (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (h2_start),
    .key     (cur_key_r),
    .divisor (prime),
    .done    (h2_done),
    .rem     (h2_rem)
  );

  // Outputs.
  assign out_valid           = out_valid_r;
  assign out_bucket_index    = o_bkt_r;
  assign out_status          = o_stat_r;
  assign out_collision_total = o_coll_r;
  assign out_slot_count      = o_slots_r;
  assign out_entries_held    = o_held_r;

endmodule
`default_nettype wire

/* hw/rtl/hti_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Hash table insert engine port checker
// Watches the top-level ports over time; bound to the top level.
// ----------------------------------------------------------------------------
module hti_checker (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        in_valid,
  input wire logic                        in_ready,
  input wire logic [hti_pkg::KEY_W-1:0]   in_key,
  input wire logic                        out_valid,
  input wire logic                        out_ready,
  input wire logic [hti_pkg::BKT_W-1:0]   out_bucket_index,
  input wire logic [1:0]                  out_status,
  input wire logic [hti_pkg::COLL_W-1:0]  out_collision_total,
  input wire logic [hti_pkg::SLOTS_W-1:0] out_slot_count,
  input wire logic [hti_pkg::HELD_W-1:0]  out_entries_held,
  input wire logic                        cfg_we,
  input wire logic [1:0]                  cfg_wdata
);
  import hti_pkg::*;

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_bucket_index) &&
      $stable(out_status) && $stable(out_collision_total))
    else $error("result word changed while stalled");

  // Reset empties the output and blocks input as the fill sweep starts.
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_ready)
    else $error("block not quiet after reset");

  // The reported bucket always lies inside the table.
  a_bkt_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> {1'b0, out_bucket_index} < out_slot_count)
    else $error("bucket index beyond slot count");

  // A grown table has more than one slot.
  a_grown: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_GROWN) |-> out_slot_count != SLOTS_W'(1))
    else $error("growth reported with a single slot");

  // One word is in work at a time.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second word taken while busy");

endmodule

bind hash_table_insert_engine hti_checker u_hti_checker (.*);
`default_nettype wire
